// ===== rtl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants of the LED column scan sequencer: field widths,
// register map, reset values, scan phase codes and the scan event bundle.
// ----------------------------------------------------------------------------
package lcs_pkg;

	// fixed widths of the transaction fields
	localparam int COL_FIELD_W   = 4;
	localparam int PLANE_FIELD_W = 4;
	localparam int WORD_FIELD_W  = 16;
	localparam int PHASE_W       = 4;
	localparam int PLANE_CNT_W   = 5;

	// register map (index = byte address / 4)
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PHASE_COUNT = 1'b0;
	localparam logic REG_PLANE_COUNT = 1'b1;

	// register reset values
	localparam logic [PHASE_W-1:0]     PHASE_COUNT_RST = 4'd5;
	localparam logic [PLANE_CNT_W-1:0] PLANE_COUNT_RST = 5'd8;

	// scan phases that do something; all others only wait
	localparam logic [PHASE_W-1:0] PH_OFF   = 4'd0;
	localparam logic [PHASE_W-1:0] PH_SEND  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_LIGHT = 4'd2;

	// per-transaction events of the scan
	typedef struct packed {
		logic                   shift_valid;
		logic                   button_strobe;
		logic [COL_FIELD_W-1:0] strobe_column;
	} scan_ev_t;

endpackage

// ===== rtl/lcs_ram.sv =====
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lcs_cfg.sv =====
// ----------------------------------------------------------------------------
// lcs_cfg
// APB register file holding phase_count and plane_count.
// ----------------------------------------------------------------------------
module lcs_cfg
	import lcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	output logic [PHASE_W-1:0]     phase_count,
	output logic [PLANE_CNT_W-1:0] plane_count
);

	logic                   reg_idx;
	logic                   wr_acc;
	logic [PHASE_W-1:0]     phase_count_q;
	logic [PLANE_CNT_W-1:0] plane_count_q;

	assign reg_idx = paddr[2];
	assign wr_acc  = psel & penable & pwrite;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_count_q <= PHASE_COUNT_RST;
			plane_count_q <= PLANE_COUNT_RST;
		end else if (wr_acc) begin
			unique case (reg_idx)
				REG_PHASE_COUNT: phase_count_q <= pwdata[PHASE_W-1:0];
				REG_PLANE_COUNT: plane_count_q <= pwdata[PLANE_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_PHASE_COUNT: prdata = APB_DATA_W'(phase_count_q);
			REG_PLANE_COUNT: prdata = APB_DATA_W'(plane_count_q);
			default:         prdata = '0;
		endcase
	end

	assign phase_count = phase_count_q;
	assign plane_count = plane_count_q;

endmodule

// ===== rtl/lcs_scan.sv =====
// ----------------------------------------------------------------------------
// lcs_scan
// Scan state: phase counter, current column, bit plane and lit column mask.
// Produces the next lit mask and the events of one tick.
// ----------------------------------------------------------------------------
module lcs_scan
	import lcs_pkg::*;
#(
	parameter int COLUMNS    = 10,
	parameter int MAX_PLANES = 16,
	parameter int CW         = $clog2(COLUMNS),
	parameter int PW         = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic [PHASE_W-1:0]     phase_count,
	input  logic [PLANE_CNT_W-1:0] plane_count,
	output logic [CW-1:0]          cur_column,
	output logic [PW-1:0]          cur_plane,
	output logic [COLUMNS-1:0]     lit_next,
	output scan_ev_t               ev
);

	logic [PHASE_W-1:0]     phase_q;
	logic [CW-1:0]          col_q;
	logic [PW-1:0]          plane_q;
	logic [COLUMNS-1:0]     lit_q;

	logic [PHASE_W-1:0]     phase_next;
	logic [CW-1:0]          col_next;
	logic [PW-1:0]          plane_next;
	logic [CW-1:0]          prev_col;
	logic [PHASE_W:0]       phase_inc;
	logic [PLANE_CNT_W-1:0] plane_inc;

	// column lit before the current one
	assign prev_col  = (col_q == '0) ? CW'(COLUMNS - 1) : col_q - CW'(1);
	assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign plane_inc = PLANE_CNT_W'(plane_q) + PLANE_CNT_W'(1);

	// next-state logic for one tick
	always_comb begin
		phase_next = phase_q;
		col_next   = col_q;
		plane_next = plane_q;
		lit_next   = lit_q;
		ev         = '0;
		if (tick) begin
			case (phase_q)
				PH_OFF: begin
					lit_next[prev_col] = 1'b0;
				end
				PH_SEND: begin
					ev.shift_valid = 1'b1;
				end
				PH_LIGHT: begin
					lit_next[col_q]  = 1'b1;
					ev.button_strobe = 1'b1;
					ev.strobe_column = COL_FIELD_W'(col_q);
					if (col_q >= CW'(COLUMNS - 1)) begin
						col_next = '0;
						if (plane_inc >= plane_count ||
						    plane_inc >= PLANE_CNT_W'(MAX_PLANES)) begin
							plane_next = '0;
						end else begin
							plane_next = PW'(plane_inc);
						end
					end else begin
						col_next = col_q + CW'(1);
					end
				end
				default: ;
			endcase
			// phase wraps as soon as it reaches the configured count
			if (phase_inc >= {1'b0, phase_count}) begin
				phase_next = '0;
			end else begin
				phase_next = phase_inc[PHASE_W-1:0];
			end
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			col_q   <= '0;
			plane_q <= '0;
			lit_q   <= '0;
		end else begin
			phase_q <= phase_next;
			col_q   <= col_next;
			plane_q <= plane_next;
			lit_q   <= lit_next;
		end
	end

	assign cur_column = col_q;
	assign cur_plane  = plane_q;

endmodule

// ===== rtl/led_column_scan_sequencer.sv =====
// ----------------------------------------------------------------------------
// led_column_scan_sequencer
// Column multiplex scanner for an LED matrix with intensity bit planes.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while in_stall is low, a scan tick or a
// pattern write, and gives one result per transaction through stage 1 (the
// store read) and the output register. The store is a COLUMNS x 2**ceil(log2
// MAX_PLANES) word RAM with a registered read; one flag per entry, cleared at
// reset, makes never-written words read as zero, so there is no clearing pass
// and the block takes transactions right after reset. The output register lets
// a new transaction in while a finished result waits to be taken. column_on is
// active-high: invert it for active-low column pins.
module led_column_scan_sequencer
	import lcs_pkg::*;
#(
	parameter int COLUMNS    = 10,
	parameter int MAX_PLANES = 16,
	parameter int WORD_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// apb configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0]    pwdata,
	output logic [APB_DATA_W-1:0]    prdata,
	output logic                     pready,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic [COL_FIELD_W-1:0]   column,
	input  logic [PLANE_FIELD_W-1:0] plane,
	input  logic [WORD_FIELD_W-1:0]  pattern,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [COLUMNS-1:0]       column_on,
	output logic                     shift_valid,
	output logic [WORD_FIELD_W-1:0]  shift_word,
	output logic                     button_strobe,
	output logic [COL_FIELD_W-1:0]   strobe_column
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int DEPTH = COLUMNS << PW;
	localparam int AW    = CW + PW;

	logic [PHASE_W-1:0]     phase_count;
	logic [PLANE_CNT_W-1:0] plane_count;

	logic                   in_acc;
	logic                   tick;
	logic                   wr_ok;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [WORD_BITS-1:0]   rd_data;
	logic [CW-1:0]          cur_column;
	logic [PW-1:0]          cur_plane;
	logic [COLUMNS-1:0]     lit_next;
	scan_ev_t               ev;

	logic [DEPTH-1:0]       filled_q;

	logic                   valid_s1;
	logic [COLUMNS-1:0]     lit_s1;
	scan_ev_t               ev_s1;
	logic                   hit_s1;
	logic                   adv_s1;

	logic                   out_valid_q;
	logic [COLUMNS-1:0]     column_on_q;
	logic                   shift_valid_q;
	logic [WORD_FIELD_W-1:0] shift_word_q;
	logic                   button_strobe_q;
	logic [COL_FIELD_W-1:0] strobe_column_q;

	// configuration registers
	lcs_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.phase_count (phase_count),
		.plane_count (plane_count)
	);

	// handshake: stage 1 drains into the output register when that is free
	assign adv_s1   = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~adv_s1;
	assign in_acc   = in_valid & ~in_stall;
	assign tick     = in_acc & ~op;

	// scan state
	lcs_scan #(
		.COLUMNS    (COLUMNS),
		.MAX_PLANES (MAX_PLANES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.phase_count (phase_count),
		.plane_count (plane_count),
		.cur_column  (cur_column),
		.cur_plane   (cur_plane),
		.lit_next    (lit_next),
		.ev          (ev)
	);

	// pattern write, out-of-range columns and planes dropped
	assign wr_ok   = in_acc & op &
	                 ((COL_FIELD_W+1)'(column) < (COL_FIELD_W+1)'(COLUMNS)) &
	                 ((PLANE_FIELD_W+1)'(plane) < (PLANE_FIELD_W+1)'(MAX_PLANES));
	assign wr_addr = {column[CW-1:0], plane[PW-1:0]};
	assign rd_addr = {cur_column, cur_plane};

	lcs_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (wr_addr),
		.wr_data (WORD_BITS'(pattern)),
		.rd_en   (ev.shift_valid),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// written flags stand in for the cleared store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (wr_ok) begin
			filled_q[wr_addr] <= 1'b1;
		end
	end

	// stage 1: waits on the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lit_s1 <= lit_next;
			ev_s1  <= ev;
			hit_s1 <= filled_q[rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			column_on_q     <= lit_s1;
			shift_valid_q   <= ev_s1.shift_valid;
			shift_word_q    <= (ev_s1.shift_valid & hit_s1) ?
			                   WORD_FIELD_W'(rd_data) : '0;
			button_strobe_q <= ev_s1.button_strobe;
			strobe_column_q <= ev_s1.strobe_column;
		end
	end

	assign out_valid     = out_valid_q;
	assign column_on     = column_on_q;
	assign shift_valid   = shift_valid_q;
	assign shift_word    = shift_word_q;
	assign button_strobe = button_strobe_q;
	assign strobe_column = strobe_column_q;

`ifndef ASSERT_OFF
	// input is only held off while stage 1 is occupied and blocked
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	// a strobed column is lit in the same result
	a_strobe_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && button_strobe) |-> (column_on[strobe_column[CW-1:0]] == 1'b1))
		else $error("strobed column is not lit");

	// no word on the shift chain without a send phase
	a_word_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !shift_valid) |-> (shift_word == '0))
		else $error("shift word without send phase");

	// a result never vanishes while stalled
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result dropped");
`endif

endmodule
